// ===== design/bbs_pkg.sv =====
`default_nettype none

package bbs_pkg;

	// sizes
	localparam int MAX_INSNS_DEF = 4096;
	localparam int LEN_W = 13;
	localparam int IDX_W = 12;
	localparam int QUEUE_DEPTH = 4;

	// opcode fields
	localparam logic [7:0] OPC_LDDW = 8'h18;
	localparam logic [2:0] CLS_JMP = 3'h5;
	localparam logic [2:0] CLS_JMP32 = 3'h6;
	localparam logic [3:0] OP_JA = 4'h0;
	localparam logic [3:0] OP_CALL = 4'h8;
	localparam logic [3:0] OP_EXIT = 4'h9;
	localparam logic [3:0] OP_BAD_E = 4'hE;
	localparam logic [3:0] OP_BAD_F = 4'hF;

	typedef enum logic [1:0] {
		KIND_EXIT = 2'd0,
		KIND_BRANCH = 2'd1,
		KIND_JUMP = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_BAD_OP = 2'd1,
		ST_RANGE = 2'd2,
		ST_NO_TERM = 2'd3
	} status_t;

	// what the front decided for one slot
	typedef enum logic [2:0] {
		ACT_NONE = 3'd0,
		ACT_EXIT = 3'd1,
		ACT_BRANCH = 3'd2,
		ACT_JUMP = 3'd3,
		ACT_BAD_OP = 3'd4,
		ACT_NO_TERM = 3'd5
	} act_t;

	typedef struct packed {
		logic [7:0] opcode;
		logic signed [15:0] offset;
		logic signed [31:0] immediate;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] block_first;
		logic [IDX_W-1:0] block_last;
		kind_t block_kind;
		logic [IDX_W-1:0] jump_target;
		status_t status;
	} out_item_t;

	// decoded slot handed from front to back (slot index travels beside it)
	typedef struct packed {
		act_t act;
		logic last;
		logic signed [31:0] rel;
	} dec_ctl_t;

endpackage

`default_nettype wire

// ===== design/bbs_front.sv =====
`default_nettype none

module bbs_front #(
	parameter int MAX_INSNS = bbs_pkg::MAX_INSNS_DEF,
	localparam int PW = $clog2(MAX_INSNS),
	localparam int LW = (bbs_pkg::LEN_W > $clog2(MAX_INSNS + 1)) ?
		bbs_pkg::LEN_W : $clog2(MAX_INSNS + 1)
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic take,
	input wire bbs_pkg::in_item_t insn,
	input wire logic [LW-1:0] len_eff,
	output logic [PW-1:0] dec_pos,
	output bbs_pkg::dec_ctl_t dec_ctl
);
	import bbs_pkg::*;

	localparam int CW = ((PW > LW) ? PW : LW) + 1;

	logic [PW-1:0] pos_q;
	logic skip_q;
	logic last;
	logic [2:0] cls;
	logic [3:0] op;

	// last slot of the program
	assign last = (CW'(pos_q) + CW'(1)) >= CW'(len_eff);
	assign cls = insn.opcode[2:0];
	assign op = insn.opcode[7:4];
	assign dec_pos = pos_q;

	// classify the slot
	always_comb begin
		dec_ctl.act = ACT_NONE;
		dec_ctl.last = last;
		dec_ctl.rel = {{16{insn.offset[15]}}, insn.offset};
		if (!skip_q && (cls == CLS_JMP || cls == CLS_JMP32)) begin
			case (op)
				OP_CALL: begin
					dec_ctl.act = ACT_NONE;
				end
				OP_EXIT: begin
					dec_ctl.act = (cls == CLS_JMP) ? ACT_EXIT : ACT_BAD_OP;
				end
				OP_JA: begin
					dec_ctl.act = ACT_JUMP;
					if (cls == CLS_JMP32) begin
						dec_ctl.rel = insn.immediate;
					end
				end
				OP_BAD_E, OP_BAD_F: begin
					dec_ctl.act = ACT_BAD_OP;
				end
				default: begin
					dec_ctl.act = ACT_BRANCH;
				end
			endcase
		end
		// anything that falls off the end of the program
		if (dec_ctl.act == ACT_NONE && last) begin
			dec_ctl.act = ACT_NO_TERM;
		end
	end

	// slot counter and wide-load skip
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			skip_q <= 1'b0;
		end else if (take) begin
			if (last) begin
				pos_q <= '0;
				skip_q <= 1'b0;
			end else begin
				pos_q <= pos_q + PW'(1);
				skip_q <= !skip_q && (insn.opcode == OPC_LDDW);
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/bbs_queue.sv =====
`default_nettype none

module bbs_queue #(
	parameter int W = 8,
	parameter int DEPTH = bbs_pkg::QUEUE_DEPTH
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire logic [W-1:0] wdata,
	input wire logic pop,
	output logic empty,
	output logic [W-1:0] rdata
);
	import bbs_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [W-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [NW-1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign full = (cnt_q == NW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + NW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - NW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/bbs_back.sv =====
`default_nettype none

module bbs_back #(
	parameter int MAX_INSNS = bbs_pkg::MAX_INSNS_DEF,
	localparam int PW = $clog2(MAX_INSNS),
	localparam int LW = (bbs_pkg::LEN_W > $clog2(MAX_INSNS + 1)) ?
		bbs_pkg::LEN_W : $clog2(MAX_INSNS + 1)
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_empty,
	input wire logic [PW-1:0] q_pos,
	input wire bbs_pkg::dec_ctl_t q_ctl,
	output logic q_pop,
	input wire logic [LW-1:0] len_eff,
	input wire logic pop,
	output logic out_valid,
	output bbs_pkg::out_item_t out_item
);
	import bbs_pkg::*;

	localparam int TW = (((PW + 2) > 33) ? (PW + 2) : 33) + 1;

	logic failed_q;
	logic [PW-1:0] cbf_q;
	logic out_valid_q;
	out_item_t out_q;

	logic take;
	logic emit;
	logic failed_d;
	logic [PW-1:0] cbf_d;
	status_t err;
	out_item_t res;
	logic signed [TW-1:0] pos_s;
	logic signed [TW-1:0] rel_s;
	logic signed [TW-1:0] len_s;
	logic signed [TW-1:0] tgt;
	logic range_bad;

	// take a slot when the result register is free or drains now
	assign take = !q_empty && (!out_valid_q || pop);
	assign q_pop = take;
	assign out_valid = out_valid_q;
	assign out_item = out_q;

	// taken target and its range check
	assign pos_s = $signed(TW'(q_pos));
	assign rel_s = TW'(q_ctl.rel);
	assign len_s = $signed(TW'(len_eff));
	assign tgt = pos_s + rel_s + $signed(TW'(1));
	assign range_bad = tgt[TW-1] || (tgt >= len_s);

	// carry out the slot
	always_comb begin
		emit = 1'b0;
		err = ST_OK;
		failed_d = failed_q;
		cbf_d = cbf_q;
		res.block_first = IDX_W'(cbf_q);
		res.block_last = IDX_W'(q_pos);
		res.block_kind = KIND_EXIT;
		res.jump_target = '0;
		res.status = ST_OK;
		if (!failed_q) begin
			case (q_ctl.act)
				ACT_EXIT: begin
					emit = 1'b1;
					cbf_d = q_pos + PW'(1);
				end
				ACT_BRANCH, ACT_JUMP: begin
					if (range_bad) begin
						err = ST_RANGE;
					end else begin
						emit = 1'b1;
						res.block_kind = (q_ctl.act == ACT_JUMP) ? KIND_JUMP : KIND_BRANCH;
						res.jump_target = IDX_W'(tgt);
						cbf_d = q_pos + PW'(1);
					end
				end
				ACT_BAD_OP: begin
					err = ST_BAD_OP;
				end
				ACT_NO_TERM: begin
					err = ST_NO_TERM;
				end
				default: begin
				end
			endcase
		end
		if (err != ST_OK) begin
			emit = 1'b1;
			res.status = err;
			failed_d = 1'b1;
		end
		// program end restarts the scan
		if (q_ctl.last) begin
			failed_d = 1'b0;
			cbf_d = '0;
		end
	end

	// block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			failed_q <= 1'b0;
			cbf_q <= '0;
		end else if (take) begin
			failed_q <= failed_d;
			cbf_q <= cbf_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && emit) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			out_q <= res;
		end
	end

	// program end leaves clean block state
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take && q_ctl.last |=> !failed_q && cbf_q == '0)
		else $error("block state not cleared at program end");

	// an error mid-program silences the rest
	a_err_sets_failed: assert property (@(posedge clk) disable iff (!arst_n)
		take && emit && res.status != ST_OK && !q_ctl.last |=> failed_q)
		else $error("error did not set failed");

	// no result comes out of a failed program
	a_silent: assert property (@(posedge clk) disable iff (!arst_n)
		take && failed_q |-> !emit)
		else $error("result emitted after error");

	// error and exit results carry no target
	a_no_target: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.block_kind == KIND_EXIT |-> out_q.jump_target == '0)
		else $error("exit or error result with target");

endmodule

`default_nettype wire

// ===== design/bpf_basic_block_scanner_unit.sv =====
// eBPF basic-block scanner.
// Input channel (push/full): one instruction slot per item, in program order,
// programs back to back. An item is taken when push is high and full is low.
// Result channel (empty/pop): one item per finished block, or one for the
// first error of a program, oldest first while empty is low; taken when pop
// is high and empty is low.
// cfg_we/cfg_wdata write program_length (slots per program); write it only
// while the block is idle.
// Throughput: one slot per cycle while not full. A result can be taken once
// its slot has passed the queue and the result register. A four-item queue
// parts the decode front from the target-check back end, and a result
// register holds the oldest result. When the receiver stalls the result
// register holds, the queue fills and full rises after four more slots;
// nothing is lost. Reset: program_length returns to 1, slot counter, block
// start, skip and error state clear, queue and result register empty.
`default_nettype none

module bpf_basic_block_scanner_unit #(
	parameter int MAX_INSNS = bbs_pkg::MAX_INSNS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire bbs_pkg::in_item_t insn,
	output logic empty,
	input wire logic pop,
	output bbs_pkg::out_item_t block,
	input wire logic cfg_we,
	input wire logic [bbs_pkg::LEN_W-1:0] cfg_wdata
);
	import bbs_pkg::*;

	localparam int PW = $clog2(MAX_INSNS);
	localparam int LW = (LEN_W > $clog2(MAX_INSNS + 1)) ? LEN_W : $clog2(MAX_INSNS + 1);
	localparam int QW = PW + $bits(dec_ctl_t);

	logic [LEN_W-1:0] program_length_q;
	logic [LW-1:0] len_eff;
	logic take;
	logic [PW-1:0] dec_pos;
	dec_ctl_t dec_ctl;
	logic q_empty;
	logic q_pop;
	logic [QW-1:0] q_rdata;
	logic [PW-1:0] q_pos;
	dec_ctl_t q_ctl;
	logic out_valid;

	// length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			program_length_q <= LEN_W'(1);
		end else if (cfg_we) begin
			program_length_q <= cfg_wdata;
		end
	end

	// clamp length to 1..MAX_INSNS
	always_comb begin
		if (program_length_q == '0) begin
			len_eff = LW'(1);
		end else if (LW'(program_length_q) > LW'(MAX_INSNS)) begin
			len_eff = LW'(MAX_INSNS);
		end else begin
			len_eff = LW'(program_length_q);
		end
	end

	assign take = push && !full;
	assign {q_pos, q_ctl} = q_rdata;
	assign empty = !out_valid;

	bbs_front #(
		.MAX_INSNS(MAX_INSNS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.insn(insn),
		.len_eff(len_eff),
		.dec_pos(dec_pos),
		.dec_ctl(dec_ctl)
	);

	bbs_queue #(
		.W(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.wdata({dec_pos, dec_ctl}),
		.pop(q_pop),
		.empty(q_empty),
		.rdata(q_rdata)
	);

	bbs_back #(
		.MAX_INSNS(MAX_INSNS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_pos(q_pos),
		.q_ctl(q_ctl),
		.q_pop(q_pop),
		.len_eff(len_eff),
		.pop(pop),
		.out_valid(out_valid),
		.out_item(block)
	);

endmodule

`default_nettype wire

// ===== tb/sv/bpf_basic_block_scanner_unit_test.sv =====
`timescale 1ns / 100ps

module bpf_basic_block_scanner_unit_test;
	import bbs_pkg::*;

	localparam int MAX_SLOTS = MAX_INSNS_DEF;
	localparam int RANDOM_ITEMS = 1900;
	localparam int SETTLE_CYCLES = 12;
	localparam int PRINT_CAP = 40;

	// opcode pieces the package does not name
	localparam logic [2:0] CLS_ALU64 = 3'h7;
	localparam logic [3:0] OP_MOV = 4'hB;
	localparam logic [3:0] OP_JEQ = 4'h1;
	localparam logic [3:0] OP_JNE = 4'h5;
	localparam logic [3:0] OP_JSLE = 4'hD;
	localparam logic SRC_IMM = 1'b0;
	localparam logic SRC_REG = 1'b1;
	// the eleven conditional ops, JEQ first
	localparam logic [43:0] COND_OPS = {4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6,
		4'h7, 4'hA, 4'hB, 4'hC, 4'hD};

	typedef struct packed {
		logic is_cfg;
		logic [LEN_W-1:0] len;
		in_item_t insn;
		logic pinned;
		out_item_t want;
	} step_t;

	logic clk = 1'b0;
	logic arst_n;
	logic push;
	logic full;
	in_item_t slot_in;
	logic empty;
	logic pop;
	out_item_t blk_out;
	logic cfg_we;
	logic [LEN_W-1:0] cfg_wdata;

	// scanner model state
	logic [LEN_W-1:0] prog_len = LEN_W'(1);
	int slot_pos = 0;
	int blk_first = 0;
	bit skip_half = 0;
	bit prog_failed = 0;

	out_item_t block_q[$];
	step_t plan[$];
	int mismatches = 0;
	int live_slots = 0;
	bit tx_burst = 0;
	bit rx_burst = 0;

	bpf_basic_block_scanner_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.insn(slot_in),
		.empty(empty),
		.pop(pop),
		.block(blk_out),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	function automatic int eff_len();
		if (prog_len == 0)
			return 1;
		if (int'(prog_len) > MAX_SLOTS)
			return MAX_SLOTS;
		return int'(prog_len);
	endfunction

	function automatic in_item_t slot_of(logic [7:0] opc, logic [15:0] off, logic [31:0] imm);
		in_item_t s;
		s.opcode = opc;
		s.offset = off;
		s.immediate = imm;
		return s;
	endfunction

	function automatic out_item_t block_of(int first, int last, kind_t k, int tgt, status_t st);
		out_item_t r;
		r.block_first = IDX_W'(first);
		r.block_last = IDX_W'(last);
		r.block_kind = k;
		r.jump_target = IDX_W'(tgt);
		r.status = st;
		return r;
	endfunction

	// advance the scanner model by one slot; returns 1 when a result is due
	function automatic bit scan_slot(input in_item_t s, output out_item_t r);
		int len;
		int pos;
		bit last;
		logic [2:0] cls;
		logic [3:0] op;
		bit term;
		bit got;
		kind_t kind;
		status_t err;
		longint target;
		len = eff_len();
		pos = slot_pos;
		last = (pos + 1 >= len);
		cls = s.opcode[2:0];
		op = s.opcode[7:4];
		term = 0;
		got = 0;
		kind = KIND_EXIT;
		err = ST_OK;
		target = 0;
		r = '0;
		if (prog_failed) begin
			// rest of a failed program is swallowed
		end else if (skip_half) begin
			skip_half = 0;
			if (last)
				err = ST_NO_TERM;
		end else begin
			if (cls == CLS_JMP || cls == CLS_JMP32) begin
				case (op)
					OP_CALL: ;
					OP_EXIT: begin
						if (cls != CLS_JMP)
							err = ST_BAD_OP;
						else
							term = 1;
					end
					OP_JA: begin
						term = 1;
						kind = KIND_JUMP;
						target = longint'(pos) + 1 + ((cls == CLS_JMP) ?
							longint'(s.offset) : longint'(s.immediate));
					end
					OP_BAD_E, OP_BAD_F: err = ST_BAD_OP;
					default: begin
						term = 1;
						kind = KIND_BRANCH;
						target = longint'(pos) + 1 + longint'(s.offset);
					end
				endcase
			end
			if (term) begin
				if (kind != KIND_EXIT && (target < 0 || target >= longint'(len))) begin
					err = ST_RANGE;
				end else begin
					r = block_of(blk_first, pos, kind, int'(target), ST_OK);
					got = 1;
					blk_first = pos + 1;
				end
			end else if (err == ST_OK) begin
				if (s.opcode == OPC_LDDW)
					skip_half = 1;
				if (last)
					err = ST_NO_TERM;
			end
		end
		if (err != ST_OK) begin
			r = block_of(blk_first, pos, KIND_EXIT, 0, err);
			got = 1;
			prog_failed = 1;
		end
		// program end puts everything back to reset
		if (last) begin
			slot_pos = 0;
			blk_first = 0;
			skip_half = 0;
			prog_failed = 0;
		end else begin
			slot_pos = pos + 1;
		end
		return got;
	endfunction

	// random slot shaped by where the model stands in the program
	function automatic in_item_t make_slot();
		int len;
		int pos;
		int roll;
		int tgt;
		int c;
		logic [2:0] cls;
		in_item_t s;
		len = eff_len();
		pos = slot_pos;
		s.opcode = 8'($urandom);
		s.offset = 16'($urandom);
		s.immediate = 32'($urandom);
		if (skip_half || prog_failed)
			return s;
		// last slot leans toward terminators
		roll = (pos + 1 >= len) ? $urandom_range(50, 99) : $urandom_range(0, 99);
		if ($urandom_range(0, 9) == 0)
			tgt = $urandom_range(0, 1) ? -1 - $urandom_range(0, 40) : len + $urandom_range(0, 40);
		else
			tgt = $urandom_range(0, len - 1);
		cls = $urandom_range(0, 1) ? CLS_JMP : CLS_JMP32;
		if (roll < 40) begin
			c = $urandom_range(0, 5);
			s.opcode[2:0] = (c == 5) ? CLS_ALU64 : 3'(c);
		end else if (roll < 50) begin
			s.opcode = OPC_LDDW;
		end else if (roll < 55) begin
			s.opcode = {OP_CALL, s.opcode[3], cls};
		end else if (roll < 72) begin
			c = $urandom_range(0, 10);
			s.opcode = {COND_OPS[c*4 +: 4], s.opcode[3], cls};
			s.offset = 16'(tgt - pos - 1);
		end else if (roll < 78) begin
			s.opcode = {OP_JA, s.opcode[3], cls};
			if (cls == CLS_JMP)
				s.offset = 16'(tgt - pos - 1);
			else
				s.immediate = 32'(tgt - pos - 1);
		end else if (roll < 87) begin
			s.opcode = {OP_EXIT, s.opcode[3], CLS_JMP};
		end else if (roll < 90) begin
			c = $urandom_range(0, 2);
			if (c == 0)
				s.opcode = {OP_EXIT, s.opcode[3], CLS_JMP32};
			else
				s.opcode = {(c == 1) ? OP_BAD_E : OP_BAD_F, s.opcode[3], cls};
		end
		return s;
	endfunction

	task automatic note_mismatch(string msg);
		if (mismatches < PRINT_CAP)
			$display("%0t: result check failed: %s", $time, msg);
		mismatches++;
	endtask

	task automatic add_cfg(int v);
		step_t st;
		st = '0;
		st.is_cfg = 1;
		st.len = LEN_W'(v);
		plan.push_back(st);
	endtask

	task automatic add_slot(in_item_t s);
		step_t st;
		st = '0;
		st.insn = s;
		plan.push_back(st);
	endtask

	task automatic add_pinned(in_item_t s, out_item_t w);
		step_t st;
		st = '0;
		st.insn = s;
		st.pinned = 1;
		st.want = w;
		plan.push_back(st);
	endtask

	// stop sending, wait for every pending result, then let the pipe go quiet
	task automatic settle();
		@(negedge clk);
		push = 0;
		while (block_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_len(int v);
		@(negedge clk);
		cfg_we = 1;
		cfg_wdata = LEN_W'(v);
		@(negedge clk);
		cfg_we = 0;
		prog_len = LEN_W'(v);
	endtask

	// offer one item, wait for the handshake, record what it should produce
	task automatic send_slot(in_item_t s, bit pinned, out_item_t want);
		int gap;
		bit got;
		out_item_t r;
		gap = tx_burst ? 0 : $urandom_range(0, 7);
		if ($urandom_range(0, 39) == 0)
			tx_burst = !tx_burst;
		@(negedge clk);
		if (gap != 0) begin
			push = 0;
			repeat (gap) @(negedge clk);
		end
		push = 1;
		slot_in = s;
		@(posedge clk);
		while (full)
			@(posedge clk);
		live_slots++;
		got = scan_slot(s, r);
		if (pinned) begin
			r = want;
			got = 1;
		end
		if (got)
			block_q.push_back(r);
	endtask

	// result side: random stalls, compare against the oldest expectation
	initial begin : result_side
		out_item_t got;
		out_item_t want;
		int stall;
		pop = 0;
		wait (arst_n === 1'b1);
		forever begin
			stall = rx_burst ? 0 : $urandom_range(0, 7);
			if ($urandom_range(0, 39) == 0)
				rx_burst = !rx_burst;
			@(negedge clk);
			if (stall != 0) begin
				pop = 0;
				repeat (stall) @(negedge clk);
			end
			pop = 1;
			@(posedge clk);
			while (empty)
				@(posedge clk);
			got = blk_out;
			if (block_q.size() == 0) begin
				note_mismatch($sformatf("unexpected item first %0d last %0d status %0d",
					got.block_first, got.block_last, got.status));
			end else begin
				want = block_q.pop_front();
				if (got.block_first !== want.block_first)
					note_mismatch($sformatf("block_first got %0d, expected %0d (last %0d)",
						got.block_first, want.block_first, want.block_last));
				if (got.block_last !== want.block_last)
					note_mismatch($sformatf("block_last got %0d, expected %0d",
						got.block_last, want.block_last));
				if (got.block_kind !== want.block_kind)
					note_mismatch($sformatf("block_kind got %0d, expected %0d (last %0d)",
						got.block_kind, want.block_kind, want.block_last));
				if (got.jump_target !== want.jump_target)
					note_mismatch($sformatf("jump_target got %0d, expected %0d (last %0d)",
						got.jump_target, want.jump_target, want.block_last));
				if (got.status !== want.status)
					note_mismatch($sformatf("status got %0d, expected %0d (last %0d)",
						got.status, want.status, want.block_last));
			end
		end
	end

	// stimulus: directed table, then random programs
	initial begin : slot_side
		int k;
		int base;
		int pick;
		int cut;
		int v;
		push = 0;
		slot_in = '0;
		cfg_we = 0;
		cfg_wdata = '0;
		arst_n = 0;
		repeat (6) @(negedge clk);
		arst_n = 1;

		// length 1 out of reset: lone exit, then lone non-jump
		add_pinned(slot_of({OP_EXIT, SRC_IMM, CLS_JMP}, 16'd0, 32'd0),
			block_of(0, 0, KIND_EXIT, 0, ST_OK));
		add_pinned(slot_of({OP_MOV, SRC_IMM, CLS_ALU64}, 16'h7FFF, 32'h8000_0000),
			block_of(0, 0, KIND_EXIT, 0, ST_NO_TERM));
		// zero length acts as one; 64-bit load as last slot
		add_cfg(0);
		add_pinned(slot_of(OPC_LDDW, 16'd0, 32'hFFFF_FFFF),
			block_of(0, 0, KIND_EXIT, 0, ST_NO_TERM));
		// load, its skipped half (looks like exit), call, exit
		add_cfg(4);
		add_slot(slot_of(OPC_LDDW, 16'd3, 32'd7));
		add_slot(slot_of({OP_EXIT, SRC_IMM, CLS_JMP}, 16'd0, 32'd0));
		add_slot(slot_of({OP_CALL, SRC_IMM, CLS_JMP}, 16'd0, 32'd1));
		add_pinned(slot_of({OP_EXIT, SRC_IMM, CLS_JMP}, 16'd0, 32'd0),
			block_of(0, 3, KIND_EXIT, 0, ST_OK));
		// skipped half on the last slot
		add_cfg(2);
		add_slot(slot_of(OPC_LDDW, 16'd0, 32'd0));
		add_pinned(slot_of({OP_JA, SRC_IMM, CLS_JMP}, 16'd0, 32'd0),
			block_of(0, 1, KIND_EXIT, 0, ST_NO_TERM));
		// oversize length clamps to the maximum: highest target, every branch op,
		// one past the end, then shrink the length to end the program
		add_cfg(8191);
		add_pinned(slot_of({OP_JA, SRC_IMM, CLS_JMP}, 16'(MAX_SLOTS - 2), 32'd0),
			block_of(0, 0, KIND_JUMP, MAX_SLOTS - 1, ST_OK));
		for (k = 0; k < 10; k++)
			add_slot(slot_of({COND_OPS[(10-k)*4 +: 4], k[1] ? SRC_REG : SRC_IMM,
				k[0] ? CLS_JMP32 : CLS_JMP}, k[0] ? 16'hFFFF : 16'd0, 32'd0));
		add_pinned(slot_of({OP_JSLE, SRC_REG, CLS_JMP}, 16'(MAX_SLOTS - 12), 32'd0),
			block_of(11, 11, KIND_EXIT, 0, ST_RANGE));
		add_cfg(1);
		add_slot(slot_of({OP_EXIT, SRC_IMM, CLS_JMP}, 16'd0, 32'd0));
		// JMP32 jump through the immediate, backward branch, length cut mid-program
		add_cfg(MAX_SLOTS);
		add_pinned(slot_of({OP_JA, SRC_IMM, CLS_JMP32}, 16'h7FFF, 32'hFFFF_FFFF),
			block_of(0, 0, KIND_JUMP, 0, ST_OK));
		add_pinned(slot_of({OP_JNE, SRC_REG, CLS_JMP}, 16'hFFFE, 32'd0),
			block_of(1, 1, KIND_BRANCH, 0, ST_OK));
		add_slot(slot_of({OP_MOV, SRC_REG, CLS_ALU64}, 16'h8000, 32'h7FFF_FFFF));
		add_cfg(1);
		add_pinned(slot_of({OP_EXIT, SRC_IMM, CLS_JMP}, 16'd0, 32'd0),
			block_of(2, 3, KIND_EXIT, 0, ST_OK));
		// unsupported jumps; after the error the program tail is silent
		add_pinned(slot_of({OP_EXIT, SRC_IMM, CLS_JMP32}, 16'd0, 32'd0),
			block_of(0, 0, KIND_EXIT, 0, ST_BAD_OP));
		add_pinned(slot_of({OP_BAD_E, SRC_IMM, CLS_JMP}, 16'd0, 32'd0),
			block_of(0, 0, KIND_EXIT, 0, ST_BAD_OP));
		add_cfg(2);
		add_pinned(slot_of({OP_BAD_F, SRC_REG, CLS_JMP32}, 16'd0, 32'd0),
			block_of(0, 0, KIND_EXIT, 0, ST_BAD_OP));
		add_slot(slot_of({OP_EXIT, SRC_IMM, CLS_JMP}, 16'd0, 32'd0));

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				settle();
				write_len(int'(plan[i].len));
			end else begin
				send_slot(plan[i].insn, plan[i].pinned, plan[i].want);
			end
		end

		// random programs, back to back unless the length changes
		base = live_slots;
		while (live_slots < base + RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 4) begin
				// oversize length, a few slots, then shrink below the current slot
				settle();
				write_len($urandom_range(MAX_SLOTS, 8191));
				cut = $urandom_range(1, 12);
				repeat (cut) send_slot(make_slot(), 0, '0);
				settle();
				write_len($urandom_range(0, slot_pos));
				send_slot(make_slot(), 0, '0);
			end else begin
				if (pick >= 55) begin
					v = $urandom_range(0, 99);
					settle();
					if (v < 5)
						write_len(0);
					else if (v < 75)
						write_len($urandom_range(1, 24));
					else
						write_len($urandom_range(25, 160));
				end
				do
					send_slot(make_slot(), 0, '0);
				while (slot_pos != 0);
			end
		end

		settle();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// hard stop well past the slowest legal run
	initial begin : watchdog
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ===== bpf_basic_block_scanner_unit.f =====
design/bbs_pkg.sv
design/bbs_front.sv
design/bbs_queue.sv
design/bbs_back.sv
design/bpf_basic_block_scanner_unit.sv
tb/sv/bpf_basic_block_scanner_unit_test.sv
